// File: sv/bap_pkg.sv
// types, codes and constants of the advertising-data structure parser
package bap_pkg;

    localparam int MAX_PAYLOAD_DEF = 255;

    localparam logic [1:0] ROLE_LENGTH  = 2'd0;
    localparam logic [1:0] ROLE_TYPE    = 2'd1;
    localparam logic [1:0] ROLE_DATA    = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_ZERO_LEN   = 2'd1;
    localparam logic [1:0] ERR_PAST_END   = 2'd2;

    localparam logic [2:0] KIND_NONE       = 3'd0;
    localparam logic [2:0] KIND_FLAGS      = 3'd1;
    localparam logic [2:0] KIND_TX_POWER   = 3'd2;
    localparam logic [2:0] KIND_MANUF      = 3'd3;
    localparam logic [2:0] KIND_APPEARANCE = 3'd4;
    localparam logic [2:0] KIND_DEV_CLASS  = 3'd5;

    localparam logic [7:0] AD_FLAGS      = 8'h01;
    localparam logic [7:0] AD_TX_POWER   = 8'h0a;
    localparam logic [7:0] AD_DEV_CLASS  = 8'h0d;
    localparam logic [7:0] AD_APPEARANCE = 8'h19;
    localparam logic [7:0] AD_MANUF      = 8'hff;

    typedef enum logic [3:0] {
        PH_LENGTH = 4'b0001,
        PH_TYPE   = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [7:0]  ad_type;
        logic [7:0]  data_index;
        logic [7:0]  data_octet;
        logic        structure_end;
        logic [1:0]  error_code;
        logic [2:0]  decoded_kind;
        logic [23:0] decoded_value;
        logic        too_short;
        logic [9:0]  appearance_category;
        logic [4:0]  major_class;
        logic        payload_end;
    } t_out_item;

endpackage

// File: sv/ble_adv_structure_parser.sv
// top level of the advertising-data structure parser
//
// Takes one payload octet per item on the input channel (i_in_valid /
// o_in_stall / i_in_item) with the payload length repeated on every octet,
// and gives one result item per octet on the output channel (o_out_valid /
// i_out_stall / o_out_item): the octet's role, structure type, data index,
// error code and, on the octet that completes a structure, the decoded value.
// o_out_valid is registered; one item can be accepted every cycle while
// o_in_stall is low. Parse state lives next to the input side and is
// updated at each accepted octet; the result goes to an output register
// backed by a one-entry skid register, so an octet is still accepted while
// a result waits. o_in_stall rises only when both registers hold results,
// and it comes straight from a register. After the last octet of a payload
// the parse state returns to its reset values.
// Reset clears the parse state and both valid flags; no result is pending.
// While o_out_valid is high and the receiver holds i_out_stall, o_out_item stays unchanged.
module ble_adv_structure_parser
    import bap_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_offset, n_offset;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_position, n_position;
    logic [23:0] r_accum, n_accum;

    logic        r_out_valid, r_skid_valid;
    t_out_item   r_out_item, r_skid_item;
    t_out_item   n_item;

    logic        in_accept, out_take;
    logic [7:0]  b;
    logic [7:0]  eff_len;
    logic        do_decode;
    logic [2:0]  dec_kind;
    logic [1:0]  dec_need;
    logic [23:0] dec_mask;
    logic [23:0] dec_value;
    logic        dec_short;

    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign b           = i_in_item.payload_byte;

    // effective payload length clamped to 1..MAX_PAYLOAD
    always_comb begin
        if (i_in_item.payload_length == 8'd0) begin
            eff_len = 8'd1;
        end else if (i_in_item.payload_length > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = i_in_item.payload_length;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_remaining = r_remaining;
        n_type      = r_type;
        n_position  = r_position;
        n_accum     = r_accum;
        do_decode   = 1'b0;
        n_item      = '0;
        n_item.data_octet = b;

        case (r_phase)
            PH_LENGTH: begin
                n_item.byte_role = ROLE_LENGTH;
                if (b == 8'd0) begin
                    n_item.error_code = ERR_ZERO_LEN;
                    n_phase           = PH_ERROR;
                end else if ({2'b00, r_offset} + 10'd1 + {2'b00, b} > {2'b00, eff_len}) begin
                    n_item.error_code = ERR_PAST_END;
                    n_phase           = PH_ERROR;
                end else begin
                    n_remaining = b;
                    n_phase     = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_item.byte_role = ROLE_TYPE;
                n_item.ad_type   = b;
                n_type           = b;
                n_position       = 8'd0;
                n_accum          = 24'd0;
                n_remaining      = r_remaining - 8'd1;
                if (n_remaining == 8'd0) begin
                    n_item.structure_end = 1'b1;
                    do_decode            = 1'b1;
                    n_phase              = PH_LENGTH;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_item.byte_role  = ROLE_DATA;
                n_item.ad_type    = r_type;
                n_item.data_index = r_position;
                case (r_position)
                    8'd0:    n_accum = r_accum | {16'd0, b};
                    8'd1:    n_accum = r_accum | {8'd0, b, 8'd0};
                    8'd2:    n_accum = r_accum | {b, 16'd0};
                    default: n_accum = r_accum;
                endcase
                n_position  = (r_position == 8'hff) ? r_position : r_position + 8'd1;
                n_remaining = r_remaining - 8'd1;
                if (n_remaining == 8'd0) begin
                    n_item.structure_end = 1'b1;
                    do_decode            = 1'b1;
                    n_phase              = PH_LENGTH;
                end
            end
            default: begin
                n_item.byte_role = ROLE_IGNORED;
            end
        endcase

        // decode of the completed structure
        case (n_type)
            AD_FLAGS: begin
                dec_kind = KIND_FLAGS;
                dec_need = 2'd1;
                dec_mask = 24'h0000ff;
            end
            AD_TX_POWER: begin
                dec_kind = KIND_TX_POWER;
                dec_need = 2'd1;
                dec_mask = 24'h0000ff;
            end
            AD_MANUF: begin
                dec_kind = KIND_MANUF;
                dec_need = 2'd2;
                dec_mask = 24'h00ffff;
            end
            AD_APPEARANCE: begin
                dec_kind = KIND_APPEARANCE;
                dec_need = 2'd2;
                dec_mask = 24'h00ffff;
            end
            AD_DEV_CLASS: begin
                dec_kind = KIND_DEV_CLASS;
                dec_need = 2'd3;
                dec_mask = 24'hffffff;
            end
            default: begin
                dec_kind = KIND_NONE;
                dec_need = 2'd0;
                dec_mask = 24'h000000;
            end
        endcase
        dec_short = n_position < {6'd0, dec_need};
        dec_value = dec_short ? 24'd0 : (n_accum & dec_mask);

        if (do_decode && dec_kind != KIND_NONE) begin
            n_item.decoded_kind  = dec_kind;
            n_item.too_short     = dec_short;
            n_item.decoded_value = dec_value;
            if (dec_kind == KIND_APPEARANCE) begin
                n_item.appearance_category = dec_value[15:6];
            end
            if (dec_kind == KIND_DEV_CLASS) begin
                n_item.major_class = dec_value[12:8];
            end
        end

        // end of payload returns all state to reset
        if ({1'b0, r_offset} + 9'd1 >= {1'b0, eff_len}) begin
            n_item.payload_end = 1'b1;
            n_phase     = PH_LENGTH;
            n_offset    = 8'd0;
            n_remaining = 8'd0;
            n_type      = 8'd0;
            n_position  = 8'd0;
            n_accum     = 24'd0;
        end else begin
            n_offset = r_offset + 8'd1;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LENGTH;
            r_offset    <= 8'd0;
            r_remaining <= 8'd0;
            r_type      <= 8'd0;
            r_position  <= 8'd0;
            r_accum     <= 24'd0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_remaining <= n_remaining;
            r_type      <= n_type;
            r_position  <= n_position;
            r_accum     <= n_accum;
        end
    end

    // output register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_accept;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_item <= r_skid_item;
            end
        end else if (!r_out_valid || out_take) begin
            if (in_accept) begin
                r_out_item <= n_item;
            end
        end else if (in_accept) begin
            r_skid_item <= n_item;
        end
    end

endmodule

// File: sv/bap_checker.sv
// port checker for the advertising-data structure parser and its bind
module bap_checker
    import bap_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    // errors come only on a length octet
    a_err_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_code != ERR_NONE
            |-> o_out_item.byte_role == ROLE_LENGTH)
        else $error("error code on a non-length octet");

    // a structure ends on its type or data octet
    a_end_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.structure_end
            |-> o_out_item.byte_role == ROLE_TYPE || o_out_item.byte_role == ROLE_DATA)
        else $error("structure end on a wrong octet");

    // decode only at a structure end
    a_dec_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.decoded_kind != KIND_NONE |-> o_out_item.structure_end)
        else $error("decode without structure end");

    // short data gives a zero value of a known kind
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.too_short
            |-> o_out_item.decoded_value == 24'd0 && o_out_item.decoded_kind != KIND_NONE)
        else $error("too short with value or without kind");

endmodule

bind ble_adv_structure_parser bap_checker u_bap_checker (.*);

// File: bench/adv_parse_checker.sv
// checker for the advertising-data structure parser: predicts each result item and compares it
module adv_parse_checker
    import bap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_pending,
    output int        o_fail_count
);

    t_out_item octet_results_due[$];

    t_phase      parse_ph = PH_LENGTH;
    logic [7:0]  offset = '0;
    logic [7:0]  octets_left = '0;
    logic [7:0]  cur_type = '0;
    logic [7:0]  dpos = '0;
    logic [23:0] acc = '0;

    t_out_item want;

    initial begin
        o_pending = 0;
        o_fail_count = 0;
    end

    task automatic clear_parse_state();
        parse_ph = PH_LENGTH;
        offset = '0;
        octets_left = '0;
        cur_type = '0;
        dpos = '0;
        acc = '0;
    endtask

    task automatic finish_structure(inout t_out_item r);
        logic [2:0]  kind;
        int          need;
        logic [23:0] v;
        kind = KIND_NONE;
        need = 0;
        v = '0;
        r.structure_end = 1'b1;
        case (cur_type)
            AD_FLAGS: begin
                kind = KIND_FLAGS;
                need = 1;
                v = acc & 24'h0000ff;
            end
            AD_TX_POWER: begin
                kind = KIND_TX_POWER;
                need = 1;
                v = acc & 24'h0000ff;
            end
            AD_MANUF: begin
                kind = KIND_MANUF;
                need = 2;
                v = acc & 24'h00ffff;
            end
            AD_APPEARANCE: begin
                kind = KIND_APPEARANCE;
                need = 2;
                v = acc & 24'h00ffff;
            end
            AD_DEV_CLASS: begin
                kind = KIND_DEV_CLASS;
                need = 3;
                v = acc;
            end
            default: kind = KIND_NONE;
        endcase
        r.decoded_kind = kind;
        if (kind != KIND_NONE) begin
            if (int'(dpos) < need) begin
                r.too_short = 1'b1;
            end else begin
                r.decoded_value = v;
                if (kind == KIND_APPEARANCE)
                    r.appearance_category = v[15:6];
                if (kind == KIND_DEV_CLASS)
                    r.major_class = v[12:8];
            end
        end
    endtask

    task automatic parse_octet(input t_in_item it, output t_out_item r);
        int         eff_len;
        logic [7:0] b;
        b = it.payload_byte;
        eff_len = (it.payload_length == 8'd0) ? 1 : int'(it.payload_length);
        if (eff_len > MAX_PAYLOAD_DEF)
            eff_len = MAX_PAYLOAD_DEF;
        r = '0;
        r.data_octet = b;
        case (parse_ph)
            PH_LENGTH: begin
                r.byte_role = ROLE_LENGTH;
                if (b == 8'd0) begin
                    r.error_code = ERR_ZERO_LEN;
                    parse_ph = PH_ERROR;
                end else if (int'(offset) + 1 + int'(b) > eff_len) begin
                    r.error_code = ERR_PAST_END;
                    parse_ph = PH_ERROR;
                end else begin
                    octets_left = b;
                    parse_ph = PH_TYPE;
                end
            end
            PH_TYPE: begin
                r.byte_role = ROLE_TYPE;
                cur_type = b;
                r.ad_type = b;
                dpos = '0;
                acc = '0;
                octets_left = octets_left - 8'd1;
                if (octets_left == 8'd0) begin
                    finish_structure(r);
                    parse_ph = PH_LENGTH;
                end else begin
                    parse_ph = PH_DATA;
                end
            end
            PH_DATA: begin
                r.byte_role = ROLE_DATA;
                r.ad_type = cur_type;
                r.data_index = dpos;
                if (dpos < 8'd3)
                    acc = acc | ({16'd0, b} << (8 * dpos));
                if (dpos < 8'd255)
                    dpos = dpos + 8'd1;
                octets_left = octets_left - 8'd1;
                if (octets_left == 8'd0) begin
                    finish_structure(r);
                    parse_ph = PH_LENGTH;
                end
            end
            default: r.byte_role = ROLE_IGNORED;
        endcase
        if (int'(offset) + 1 >= eff_len) begin
            r.payload_end = 1'b1;
            clear_parse_state();
        end else begin
            offset = offset + 8'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse_state();
            octet_results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (octet_results_due.size() == 0) begin
                    $error("result item with no octet waiting for it");
                    o_fail_count++;
                end else begin
                    want = octet_results_due.pop_front();
                    check_field("byte_role", want.byte_role, i_out_item.byte_role);
                    check_field("ad_type", want.ad_type, i_out_item.ad_type);
                    check_field("data_index", want.data_index, i_out_item.data_index);
                    check_field("data_octet", want.data_octet, i_out_item.data_octet);
                    check_field("structure_end", want.structure_end,
                                i_out_item.structure_end);
                    check_field("error_code", want.error_code, i_out_item.error_code);
                    check_field("decoded_kind", want.decoded_kind, i_out_item.decoded_kind);
                    check_field("decoded_value", want.decoded_value,
                                i_out_item.decoded_value);
                    check_field("too_short", want.too_short, i_out_item.too_short);
                    check_field("appearance_category", want.appearance_category,
                                i_out_item.appearance_category);
                    check_field("major_class", want.major_class, i_out_item.major_class);
                    check_field("payload_end", want.payload_end, i_out_item.payload_end);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_octet(i_in_item, want);
                octet_results_due.push_back(want);
            end
        end
        o_pending <= octet_results_due.size();
    end

endmodule

// File: bench/tb_ble_adv_structure_parser.sv
// testbench top for the advertising-data structure parser: stimulus, stall pattern and verdict
module tb_ble_adv_structure_parser;
    import bap_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TARGET = 840;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        pending;
    int        fail_count;

    logic [7:0] octets[$];
    int         sent = 0;
    int         burst_left = 0;
    int         cycle_count = 0;
    int         stall_mode = 0;
    int         mode_left = 0;
    logic [3:0] stall_tick = '0;

    ble_adv_structure_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    adv_parse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern: modes of random length
    always @(posedge clk) begin
        stall_tick <= stall_tick + 4'd1;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_tick[3];
        endcase
    end

    task automatic send_octet(input logic [7:0] b, input logic [7:0] len);
        int       gap;
        t_in_item it;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        it.payload_byte = b;
        it.payload_length = len;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_payload(input logic [7:0] len, input int cut_at,
                                input logic [7:0] len2);
        foreach (octets[i])
            send_octet(octets[i], (i >= cut_at) ? len2 : len);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int         payloads;
        int         pick;
        int         total;
        int         room;
        int         slen;
        int         cut_at;
        logic [7:0] len_field;
        logic [7:0] len2;
        logic [7:0] typ;

        payloads = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        octets = '{8'hff};
        send_payload(8'd0, 999, 8'd0);
        octets = '{8'h00, 8'haa, 8'hbb};
        send_payload(8'd3, 999, 8'd0);
        octets = '{8'h01, 8'h55};
        send_payload(8'd2, 999, 8'd0);
        octets = '{8'h02, AD_FLAGS, 8'h06};
        send_payload(8'd3, 999, 8'd0);
        octets = '{8'h03, AD_APPEARANCE, 8'hc1, 8'h03};
        send_payload(8'd4, 999, 8'd0);
        octets = '{8'h03, AD_DEV_CLASS, 8'h11, 8'h22};
        send_payload(8'd4, 999, 8'd0);
        octets = '{8'h04, AD_DEV_CLASS, 8'h0c, 8'h1f, 8'h5a};
        send_payload(8'd5, 999, 8'd0);
        octets = '{8'h03, AD_MANUF, 8'h4c, 8'h00};
        send_payload(8'd4, 999, 8'd0);
        octets = '{8'h02, AD_TX_POWER, 8'h80};
        send_payload(8'd3, 999, 8'd0);
        wait_all_results();

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 15);
            total = ($urandom_range(0, 11) == 0) ? $urandom_range(32, 255)
                                                 : $urandom_range(2, 31);
            len_field = 8'(total);
            cut_at = total;
            len2 = len_field;
            octets.delete();
            if (pick == 11 || pick == 12) begin
                repeat (total) octets.push_back(8'($urandom_range(0, 255)));
                if (pick == 12)
                    len_field = 8'($urandom_range(0, 255));
            end else begin
                room = total;
                while (room > 0) begin
                    if ($urandom_range(0, 15) == 0) begin
                        // zero padding to the end
                        repeat (room) octets.push_back(8'h00);
                        room = 0;
                    end else if (room == 1) begin
                        octets.push_back(8'($urandom_range(0, 255)));
                        room = 0;
                    end else begin
                        slen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, room - 1)
                             : $urandom_range(1, (room > 7) ? 6 : room - 1);
                        case ($urandom_range(0, 6))
                            0: typ = AD_FLAGS;
                            1: typ = AD_TX_POWER;
                            2: typ = AD_MANUF;
                            3: typ = AD_APPEARANCE;
                            4: typ = AD_DEV_CLASS;
                            default: typ = 8'($urandom_range(0, 255));
                        endcase
                        octets.push_back(8'(slen));
                        octets.push_back(typ);
                        repeat (slen - 1) octets.push_back(8'($urandom_range(0, 255)));
                        room -= slen + 1;
                    end
                end
                if (pick == 13)
                    octets[$urandom_range(0, total - 1)] = 8'($urandom_range(0, 255));
                if (pick == 14) begin
                    cut_at = $urandom_range(1, total - 1);
                    len2 = 8'($urandom_range(0, 255));
                end
                if (pick == 15)
                    len_field = 8'($urandom_range(0, 255));
            end
            send_payload(len_field, cut_at, len2);
            payloads++;
            if (payloads % 8 == 0)
                wait_all_results();
        end

        wait_all_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
